// ===== sv/pft_pkg.sv =====
// Shared types and constants for the proportional follow tracker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package pft_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned ScrW    = 14;
  localparam int unsigned SpdW    = 24;
  localparam int unsigned FracW   = 8;
  localparam int unsigned MagW    = 33;              // |pos - follower|
  localparam int unsigned SumW    = 66;              // dx^2 + dy^2
  localparam int unsigned RootW   = 33;              // floor(sqrt(sum))
  localparam int unsigned ProdW   = 49;              // speed * frame_time, len << 16
  localparam int unsigned NumW    = 82;              // |d| * speed * frame_time
  localparam int unsigned QuoW    = 41;              // quotient up to the move cap
  localparam int unsigned CntW    = 7;
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned DivSteps  = NumW;
  localparam logic [QuoW-1:0] MoveCap = {1'b1, {(QuoW-1){1'b0}}};

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam logic [1:0] RegMinSpeed = 2'd0;
  localparam logic [1:0] RegDeadZone = 2'd1;
  localparam logic [1:0] RegFraction = 2'd2;
  localparam logic [SpdW-1:0]  MinSpeedRst = 24'd7680;
  localparam logic [SpdW-1:0]  DeadZoneRst = 24'd2560;
  localparam logic [FracW-1:0] FractionRst = 8'd205;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [TimeW-1:0]       frame_time;
    logic [ScrW-1:0]        screen_width;
    logic [ScrW-1:0]        screen_height;
    logic                   snap;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] follow_x;
    logic signed [PosW-1:0] follow_y;
    logic [ScrW-1:0]        offset_x;
    logic [ScrW-1:0]        offset_y;
    logic                   moved;
  } out_item_t;

  typedef struct packed {
    logic [SpdW-1:0]  min_speed;
    logic [SpdW-1:0]  dead_zone;
    logic [FracW-1:0] follow_fraction;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQR_X, ST_SQR_Y, ST_ROOT, ST_SPEED, ST_PROD,
    ST_MUL_LO, ST_MUL_HI, ST_DIVIDE, ST_APPLY, ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic sq_x;
    logic sq_y;
    logic root_step;
    logic speed;
    logic prod;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic apply;
    logic axis;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic snap;
    logic len_gt;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/pft_if.sv =====
// Valid/ready channel interfaces for input and result items.
// Depends on pft_pkg for the payload structs.
`timescale 1ns / 1ps
`default_nettype none
interface pft_in_if import pft_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pft_out_if import pft_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/pft_regs.sv =====
// APB register file: min_speed, dead_zone, follow_fraction.
// Depends on pft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pft_regs import pft_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);
  cfg_t cfg_q;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_speed       <= MinSpeedRst;
      cfg_q.dead_zone       <= DeadZoneRst;
      cfg_q.follow_fraction <= FractionRst;
    end else if (wr) begin
      case (paddr[3:2])
        RegMinSpeed: cfg_q.min_speed       <= pwdata[SpdW-1:0];
        RegDeadZone: cfg_q.dead_zone       <= pwdata[SpdW-1:0];
        RegFraction: cfg_q.follow_fraction <= pwdata[FracW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegMinSpeed: prdata = DataW'(cfg_q.min_speed);
      RegDeadZone: prdata = DataW'(cfg_q.dead_zone);
      RegFraction: prdata = DataW'(cfg_q.follow_fraction);
      default:     prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/pft_dp.sv =====
// Datapath: squares, bit-serial square root, speed product, split multiply,
// bit-serial divider, saturating update and result register. Depends on pft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pft_dp import pft_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cmd_t     cmd_i,
  input  wire in_item_t in_i,
  input  wire cfg_t     cfg_i,
  output sts_t          sts_o,
  output out_item_t     out_o
);
  logic signed [PosW-1:0] px_q, py_q, fx_q, fy_q, fx_d, fy_d;
  logic [TimeW-1:0]  ft_q;
  logic [ScrW-1:0]   w_q, h_q;
  logic              snap_q, moved_q;
  logic [MagW-1:0]   ax_q, ay_q;
  logic              nx_q, ny_q;
  logic [SumW-1:0]   sum_q;
  logic [RootW:0]    rem_q;
  logic [RootW-1:0]  root_q;
  logic [RootW-1:0]  speed_q;
  logic [ProdW-1:0]  p_q;
  logic [NumW-1:0]   num_q;
  logic [ProdW-1:0]  r_q;
  logic [QuoW-1:0]   q_q;
  logic              sticky_q;
  out_item_t         out_q;

  logic signed [MagW-1:0] dx, dy;
  logic [RootW+2:0]  rs, trial;
  logic [RootW+FracW-1:0] spd_full;
  logic [RootW-1:0]  spd_raw;
  logic [MagW-1:0]   a_sel;
  logic [ProdW:0]    drs, dden;
  logic [QuoW-1:0]   mag;
  logic signed [QuoW:0] fsel, fnew;
  logic signed [PosW-1:0] fsat;
  logic              nsel;

  assign dx = MagW'(in_i.pos_x) - MagW'(fx_q);
  assign dy = MagW'(in_i.pos_y) - MagW'(fy_q);

  // square root step: two radicand bits per cycle, MSB pair first
  assign rs    = {rem_q, sum_q[SumW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  assign spd_full = (RootW+FracW)'(cfg_i.follow_fraction) * (RootW+FracW)'(root_q);
  assign spd_raw  = spd_full[RootW+FracW-1:FracW];

  assign a_sel = cmd_i.axis ? ay_q : ax_q;
  assign nsel  = cmd_i.axis ? ny_q : nx_q;

  // divide step against len << 16
  assign drs  = {r_q, num_q[NumW-1]};
  assign dden = {1'b0, root_q, {TimeW{1'b0}}};

  assign mag  = (sticky_q || q_q > MoveCap) ? MoveCap : q_q;
  assign fsel = cmd_i.axis ? (QuoW+1)'(fy_q) : (QuoW+1)'(fx_q);
  assign fnew = nsel ? fsel - $signed({1'b0, mag}) : fsel + $signed({1'b0, mag});

  always_comb begin
    if (fnew > (QuoW+1)'(signed'(32'sh7FFFFFFF)))       fsat = 32'sh7FFFFFFF;
    else if (fnew < (QuoW+1)'(signed'(32'sh80000000)))  fsat = 32'sh80000000;
    else                                                fsat = fnew[PosW-1:0];
  end

  always_comb begin
    fx_d = fx_q;
    fy_d = fy_q;
    if (cmd_i.apply && !cmd_i.axis) fx_d = fsat;
    if (cmd_i.apply &&  cmd_i.axis) fy_d = fsat;
    if (cmd_i.out_load && snap_q) begin
      fx_d = px_q;
      fy_d = py_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= '0;
      fy_q <= '0;
    end else begin
      fx_q <= fx_d;
      fy_q <= fy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q    <= in_i.pos_x;
      py_q    <= in_i.pos_y;
      ft_q    <= in_i.frame_time;
      w_q     <= in_i.screen_width;
      h_q     <= in_i.screen_height;
      snap_q  <= in_i.snap;
      moved_q <= 1'b0;
      nx_q    <= dx[MagW-1];
      ny_q    <= dy[MagW-1];
      ax_q    <= dx[MagW-1] ? MagW'(-dx) : MagW'(dx);
      ay_q    <= dy[MagW-1] ? MagW'(-dy) : MagW'(dy);
    end
    if (cmd_i.sq_x) begin
      sum_q  <= SumW'(ax_q) * SumW'(ax_q);
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sq_y) sum_q <= sum_q + SumW'(ay_q) * SumW'(ay_q);
    if (cmd_i.root_step) begin
      sum_q <= {sum_q[SumW-3:0], 2'b00};
      if (rs >= trial) begin
        rem_q  <= (RootW+1)'(rs - trial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rs[RootW:0];
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.speed)
      speed_q <= (spd_raw < RootW'(cfg_i.min_speed)) ? RootW'(cfg_i.min_speed) : spd_raw;
    if (cmd_i.prod) p_q <= ProdW'(speed_q) * ProdW'(ft_q);
    if (cmd_i.mul_lo) begin
      num_q    <= NumW'(65'(a_sel) * 65'(p_q[31:0]));
      r_q      <= '0;
      q_q      <= '0;
      sticky_q <= 1'b0;
    end
    if (cmd_i.mul_hi)
      num_q <= num_q + {50'(a_sel) * 50'(p_q[ProdW-1:32]), 32'b0};
    if (cmd_i.div_step) begin
      num_q    <= {num_q[NumW-2:0], 1'b0};
      sticky_q <= sticky_q | q_q[QuoW-1];
      if (drs >= dden) begin
        r_q <= ProdW'(drs - dden);
        q_q <= {q_q[QuoW-2:0], 1'b1};
      end else begin
        r_q <= drs[ProdW-1:0];
        q_q <= {q_q[QuoW-2:0], 1'b0};
      end
    end
    if (cmd_i.apply) moved_q <= 1'b1;
    if (cmd_i.out_load) begin
      out_q.follow_x <= snap_q ? px_q : fx_q;
      out_q.follow_y <= snap_q ? py_q : fy_q;
      out_q.offset_x <= w_q;
      out_q.offset_y <= h_q;
      out_q.moved    <= moved_q;
    end
  end

  assign sts_o.snap   = snap_q;
  assign sts_o.len_gt = root_q > RootW'(cfg_i.dead_zone);
  assign out_o        = out_q;
endmodule
`default_nettype wire

// ===== sv/pft_ctrl.sv =====
// Controller: sequences the datapath one item at a time and owns the
// handshake flags. Depends on pft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pft_ctrl import pft_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);
  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic axis_q, axis_d, out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQR_X;
      ST_SQR_X:  state_d = sts_i.snap ? ST_DONE : ST_SQR_Y;
      ST_SQR_Y:  state_d = ST_ROOT;
      ST_ROOT:   if (cnt_q == CntW'(SqrtSteps - 1)) state_d = ST_SPEED;
      ST_SPEED:  state_d = sts_i.len_gt ? ST_PROD : ST_DONE;
      ST_PROD:   state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_DIVIDE;
      ST_DIVIDE: if (cnt_q == CntW'(DivSteps - 1)) state_d = ST_APPLY;
      ST_APPLY:  state_d = axis_q ? ST_DONE : ST_MUL_LO;
      ST_DONE:   if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    in_ready_o  = 1'b0;
    cnt_d       = '0;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SQR_X: cmd_o.sq_x = 1'b1;
      ST_SQR_Y: cmd_o.sq_y = 1'b1;
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end
      ST_SPEED: cmd_o.speed = 1'b1;
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        axis_d = 1'b0;
      end
      ST_MUL_LO: cmd_o.mul_lo = 1'b1;
      ST_MUL_HI: cmd_o.mul_hi = 1'b1;
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        axis_d = !axis_q;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
    if (state_d != state_q) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule
`default_nettype wire

// ===== sv/proportional_follow_tracker.sv =====
// Top level of the proportional follow tracker: register file, controller, datapath.
// Depends on pft_pkg, pft_if, pft_regs, pft_ctrl and pft_dp.
//
//   channel  | dir | handshake      | carries
//   ---------+-----+----------------+------------------------------------------
//   in_i     | in  | valid/ready    | pos_x, pos_y, frame_time, screen size, snap
//   out_o    | out | valid/ready    | follow_x, follow_y, offset_x/y, moved
//   APB      | in  | psel/penable   | min_speed, dead_zone, follow_fraction
//
// One item at a time. A snap item goes to the output after the first square; a
// follow item inside the dead zone stops after the 33-step square root and the
// speed step; a moving item also runs the 82-step shared divider once per axis.
// Reset clears the follower point to zero and loads the register defaults.
// A finished result sits in the output register; the next item is accepted
// meanwhile and only stalls at the end if the previous result is still unread.
`timescale 1ns / 1ps
`default_nettype none
module proportional_follow_tracker import pft_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  pft_in_if.sink                in_i,
  pft_out_if.source             out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);
  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  pft_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  pft_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pft_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd),
    .in_i  (in_i.payload),
    .cfg_i (cfg),
    .sts_o (sts),
    .out_o (out_o.payload)
  );
endmodule
`default_nettype wire
